### hdl/rmth_pkg.sv
package rmth_pkg;

  localparam int HEAP_DEPTH = 512;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int SIZE_W     = IDX_W + 1;
  localparam int CNT_W      = IDX_W + 2;
  localparam int DATA_W     = 32;
  localparam int OUT_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

  localparam logic SEL_LOWER = 1'b0;
  localparam logic SEL_UPPER = 1'b1;

  typedef struct packed {
    logic load;
    logic dispatch;
    logic push_init;
    logic push_chk;
    logic push_cmp;
    logic rep_init;
    logic rep_rdl;
    logic rep_rdr;
    logic rep_cmp;
    logic second;
    logic med;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic repl;
    logic pend;
    logic i_zero;
    logic push_stop;
    logic rep_stop;
  } status_t;

  // lower heap is a max-heap, upper heap a min-heap
  function automatic logic above(logic signed [DATA_W-1:0] a,
                                 logic signed [DATA_W-1:0] b, logic sel);
    logic r;
    r = (sel == SEL_LOWER) ? (a > b) : (a < b);
    return r;
  endfunction

endpackage

### hdl/rmth_ctrl.sv
module rmth_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  rmth_pkg::status_t  st,
  output rmth_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_PUSH_INIT = 4'd2;
  localparam logic [3:0] S_PUSH_CHK = 4'd3;
  localparam logic [3:0] S_PUSH_CMP = 4'd4;
  localparam logic [3:0] S_REP_INIT = 4'd5;
  localparam logic [3:0] S_REP_RDL  = 4'd6;
  localparam logic [3:0] S_REP_RDR  = 4'd7;
  localparam logic [3:0] S_REP_CMP  = 4'd8;
  localparam logic [3:0] S_SECOND   = 4'd9;
  localparam logic [3:0] S_MED      = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0] state, state_next;
  logic       m_tvalid_next;
  logic [3:0] op_end;

  assign s_tready = (state == S_IDLE);
  assign op_end   = st.pend ? S_SECOND : S_MED;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        if (st.full) state_next = S_MED;
        else if (st.repl) state_next = S_REP_INIT;
        else state_next = S_PUSH_INIT;
      end
      S_PUSH_INIT: begin
        cmd.push_init = 1'b1;
        state_next    = S_PUSH_CHK;
      end
      S_PUSH_CHK: begin
        cmd.push_chk = 1'b1;
        state_next   = st.i_zero ? op_end : S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        cmd.push_cmp = 1'b1;
        state_next   = st.push_stop ? op_end : S_PUSH_CHK;
      end
      S_REP_INIT: begin
        cmd.rep_init = 1'b1;
        state_next   = S_REP_RDL;
      end
      S_REP_RDL: begin
        cmd.rep_rdl = 1'b1;
        state_next  = S_REP_RDR;
      end
      S_REP_RDR: begin
        cmd.rep_rdr = 1'b1;
        state_next  = S_REP_CMP;
      end
      S_REP_CMP: begin
        cmd.rep_cmp = 1'b1;
        state_next  = st.rep_stop ? op_end : S_REP_RDL;
      end
      S_SECOND: begin
        cmd.second = 1'b1;
        state_next = S_PUSH_INIT;
      end
      S_MED: begin
        cmd.med    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.publish   = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

### hdl/rmth_datapath.sv
module rmth_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [rmth_pkg::DATA_W-1:0]           sample,
  input  rmth_pkg::cmd_t                        cmd,
  output rmth_pkg::status_t                     st,
  output logic [rmth_pkg::DATA_W-1:0]           median_floor,
  output logic                                  dropped,
  output logic [rmth_pkg::CNT_W-1:0]            sample_count
);

  localparam int DW = rmth_pkg::DATA_W;
  localparam int SW = rmth_pkg::SIZE_W;
  localparam int AW = rmth_pkg::IDX_W;

  logic signed [DW-1:0] lower_mem [rmth_pkg::HEAP_DEPTH];
  logic signed [DW-1:0] upper_mem [rmth_pkg::HEAP_DEPTH];
  logic signed [DW-1:0] lower_rd, upper_rd, rd;

  logic [SW-1:0] lower_size, upper_size, cur_size;
  logic signed [DW-1:0] lower_root, upper_root;
  logic signed [DW-1:0] x, v, spare, best_v, fin_v, med;
  logic [SW:0]   i, l, r, p, best_i, fin_i;
  logic          sel, pend, full, repl, drop_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic signed [DW-1:0] wdata;
  logic          to_lower, to_lower_r;
  logic signed [DW:0] sum;

  assign rd       = sel ? upper_rd : lower_rd;
  assign cur_size = sel ? upper_size : lower_size;
  assign l        = {i[SW-1:0], 1'b1};
  assign r        = l + 1'b1;
  assign p        = (i - 1'b1) >> 1;

  always_comb begin
    if (lower_size != '0) to_lower = ($signed(sample) <= lower_root);
    else if (upper_size != '0) to_lower = ($signed(sample) <= upper_root);
    else to_lower = 1'b1;
  end

  // root moves when target heap is larger (upper: also x > upper_root)
  assign repl = to_lower_r ? (lower_size > upper_size)
                           : ((upper_size > lower_size) && (x > upper_root));

  // first child candidate, then second
  always_comb begin
    if ((l < {1'b0, cur_size}) && rmth_pkg::above(rd, v, sel)) begin
      best_v = rd;
      best_i = l;
    end else begin
      best_v = v;
      best_i = i;
    end
  end

  logic signed [DW-1:0] hold_v;
  logic [SW:0]          hold_i;
  always_comb begin
    if ((r < {1'b0, cur_size}) && rmth_pkg::above(rd, hold_v, sel)) begin
      fin_v = rd;
      fin_i = r;
    end else begin
      fin_v = hold_v;
      fin_i = hold_i;
    end
  end

  assign st.full      = full;
  assign st.repl      = repl;
  assign st.pend      = pend;
  assign st.i_zero    = (i == '0);
  assign st.push_stop = !rmth_pkg::above(v, rd, sel);
  assign st.rep_stop  = (fin_i == i);

  always_comb begin
    we    = 1'b0;
    waddr = i[AW-1:0];
    wdata = v;
    raddr = p[AW-1:0];
    if (cmd.push_chk) begin
      we = st.i_zero;
    end else if (cmd.push_cmp) begin
      we    = 1'b1;
      wdata = st.push_stop ? v : rd;
    end else if (cmd.rep_rdl) begin
      raddr = l[AW-1:0];
    end else if (cmd.rep_rdr) begin
      raddr = r[AW-1:0];
    end else if (cmd.rep_cmp) begin
      we    = 1'b1;
      wdata = st.rep_stop ? v : fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (we && sel == rmth_pkg::SEL_LOWER) lower_mem[waddr] <= wdata;
    if (we && sel == rmth_pkg::SEL_UPPER) upper_mem[waddr] <= wdata;
    lower_rd <= lower_mem[raddr];
    upper_rd <= upper_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_size <= '0;
      upper_size <= '0;
      pend       <= 1'b0;
    end else begin
      if (cmd.dispatch) pend <= !full && repl;
      if (cmd.second) pend <= 1'b0;
      if (cmd.push_init) begin
        if (sel) upper_size <= upper_size + 1'b1;
        else lower_size <= lower_size + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x          <= sample;
      to_lower_r <= to_lower;
      full <= ({1'b0, lower_size} + {1'b0, upper_size}) >=
              (SW+1)'(2 * rmth_pkg::HEAP_DEPTH);
    end
    if (cmd.dispatch) begin
      v <= x;
      if (to_lower_r) begin
        sel   <= rmth_pkg::SEL_LOWER;
        spare <= lower_root;
      end else if ((upper_size > lower_size) && (x <= upper_root)) begin
        sel <= rmth_pkg::SEL_LOWER;
      end else begin
        sel   <= rmth_pkg::SEL_UPPER;
        spare <= upper_root;
      end
    end
    if (cmd.second) begin
      sel <= ~sel;
      v   <= spare;
    end
    if (cmd.push_init) i <= {1'b0, cur_size};
    if (cmd.rep_init) i <= '0;
    if (cmd.push_cmp && !st.push_stop) i <= p;
    if (cmd.rep_rdr) begin
      hold_v <= best_v;
      hold_i <= best_i;
    end
    if (cmd.rep_cmp && !st.rep_stop) i <= fin_i;
    if (we && waddr == '0) begin
      if (sel) upper_root <= wdata;
      else lower_root <= wdata;
    end
    if (cmd.med) med <= (lower_size == upper_size) ? DW'(sum >>> 1)
                        : (lower_size > upper_size) ? lower_root : upper_root;
    if (cmd.load) drop_r <= 1'b0;
    if (cmd.dispatch) drop_r <= full;
    if (cmd.publish) begin
      median_floor <= med;
      dropped      <= drop_r;
      sample_count <= {1'b0, lower_size} + {1'b0, upper_size};
    end
  end

  assign sum = {lower_root[DW-1], lower_root} + {upper_root[DW-1], upper_root};

endmodule

### hdl/running_median_two_heaps_top.sv
// A pushed sample climbs its heap level by level; a root replace sifts the new sample down
// from the root, then pushes the old root into the other heap; a sample dropped at capacity
// is not stored.
// Flow: one transaction at a time; the next sample can be taken in the same cycle as tvalid
// rises. A new sample is taken while the last result waits.
// Reset (rst, synchronous, active high) empties both heaps and clears tvalid.
module running_median_two_heaps_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [rmth_pkg::DATA_W-1:0]            s_tdata,  // sample
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [rmth_pkg::OUT_TDATA_W-1:0]       m_tdata,  // median_floor, sample_count, pad
  output logic                                   m_tuser   // dropped
);

  rmth_pkg::cmd_t    cmd;
  rmth_pkg::status_t st;
  logic [rmth_pkg::DATA_W-1:0] median_floor;
  logic [rmth_pkg::CNT_W-1:0]  sample_count;

  rmth_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rmth_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample       (s_tdata),
    .cmd          (cmd),
    .st           (st),
    .median_floor (median_floor),
    .dropped      (m_tuser),
    .sample_count (sample_count)
  );

  assign m_tdata = {{(rmth_pkg::OUT_TDATA_W - rmth_pkg::DATA_W - rmth_pkg::CNT_W){1'b0}},
                    sample_count, median_floor};

endmodule

### hdl/rmth_checker.sv
module rmth_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [rmth_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic                               m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      m_tdata[rmth_pkg::DATA_W +: rmth_pkg::CNT_W] ==
      rmth_pkg::CNT_W'(2 * rmth_pkg::HEAP_DEPTH))
    else $error("drop flagged below capacity");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[rmth_pkg::DATA_W +: rmth_pkg::CNT_W] != '0)
    else $error("result with empty heaps");

endmodule

bind running_median_two_heaps_top rmth_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int DATA_W      = rmth_pkg::DATA_W;
  localparam int CNT_W       = rmth_pkg::CNT_W;
  localparam int OUT_TDATA_W = rmth_pkg::OUT_TDATA_W;
  localparam int HEAP_DEPTH  = rmth_pkg::HEAP_DEPTH;
  localparam int TOTAL_CAP   = 2 * HEAP_DEPTH;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [DATA_W-1:0] median_floor;
    logic                     dropped;
    logic [CNT_W-1:0]         sample_count;
  } median_res_t;

  // golden running median kept in two heaps, plus the queue of pending results
  class median_scoreboard;
    logic signed [DATA_W-1:0] lo_heap[HEAP_DEPTH];
    logic signed [DATA_W-1:0] hi_heap[HEAP_DEPTH];
    int unsigned lo_n;
    int unsigned hi_n;
    median_res_t pending[$];
    int          errors;
    int          checked;
    int          drops_seen;

    function new();
      lo_n = 0;
      hi_n = 0;
      errors = 0;
      checked = 0;
      drops_seen = 0;
    endfunction

    function bit ranks_higher(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b,
                              bit is_max);
      return is_max ? (a > b) : (a < b);
    endfunction

    function void sift_push(bit is_max, logic signed [DATA_W-1:0] v);
      int unsigned i;
      int unsigned p;
      logic signed [DATA_W-1:0] t;
      if (is_max) begin
        i = lo_n; lo_heap[i] = v; lo_n++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!ranks_higher(lo_heap[i], lo_heap[p], 1)) break;
          t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t; i = p;
        end
      end else begin
        i = hi_n; hi_heap[i] = v; hi_n++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!ranks_higher(hi_heap[i], hi_heap[p], 0)) break;
          t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t; i = p;
        end
      end
    endfunction

    function void swap_root(bit is_max, logic signed [DATA_W-1:0] v);
      int unsigned i;
      int unsigned l;
      int unsigned best;
      int unsigned n;
      logic signed [DATA_W-1:0] t;
      i = 0;
      n = is_max ? lo_n : hi_n;
      if (is_max) lo_heap[0] = v; else hi_heap[0] = v;
      forever begin
        l = 2 * i + 1;
        best = i;
        if (is_max) begin
          if (l < n && lo_heap[l] > lo_heap[best]) best = l;
          if (l + 1 < n && lo_heap[l+1] > lo_heap[best]) best = l + 1;
          if (best == i) break;
          t = lo_heap[i]; lo_heap[i] = lo_heap[best]; lo_heap[best] = t;
        end else begin
          if (l < n && hi_heap[l] < hi_heap[best]) best = l;
          if (l + 1 < n && hi_heap[l+1] < hi_heap[best]) best = l + 1;
          if (best == i) break;
          t = hi_heap[i]; hi_heap[i] = hi_heap[best]; hi_heap[best] = t;
        end
        i = best;
      end
    endfunction

    function logic signed [DATA_W-1:0] median_now();
      logic signed [DATA_W:0] s;
      if (lo_n == 0 && hi_n == 0) return '0;
      if (lo_n == hi_n) begin
        s = $signed({lo_heap[0][DATA_W-1], lo_heap[0]})
            + $signed({hi_heap[0][DATA_W-1], hi_heap[0]});
        return s[DATA_W:1];
      end
      return (lo_n > hi_n) ? lo_heap[0] : hi_heap[0];
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] x);
      median_res_t r;
      logic signed [DATA_W-1:0] moved;
      bit goes_low;
      r.dropped = 1'b0;
      if (lo_n + hi_n >= TOTAL_CAP) begin
        r.dropped = 1'b1;
      end else begin
        if (lo_n > 0) goes_low = (x <= lo_heap[0]);
        else if (hi_n > 0) goes_low = (x <= hi_heap[0]);
        else goes_low = 1;
        if (goes_low) begin
          if (lo_n > hi_n) begin
            moved = lo_heap[0];
            swap_root(1, x);
            sift_push(0, moved);
          end else begin
            sift_push(1, x);
          end
        end else if (hi_n > lo_n) begin
          if (x <= hi_heap[0]) begin
            sift_push(1, x);
          end else begin
            moved = hi_heap[0];
            swap_root(0, x);
            sift_push(1, moved);
          end
        end else begin
          sift_push(0, x);
        end
      end
      r.median_floor = median_now();
      r.sample_count = CNT_W'(lo_n + hi_n);
      pending = {pending, r};
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic drop);
      median_res_t e;
      logic signed [DATA_W-1:0] med;
      logic [CNT_W-1:0] cnt;
      med = data[DATA_W-1:0];
      cnt = data[DATA_W +: CNT_W];
      if (pending.size() == 0) begin
        $error("result with nothing pending: median_floor %0d", med);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (drop) drops_seen++;
      if (med !== e.median_floor) begin
        $error("median_floor expected %0d actual %0d", e.median_floor, med);
        errors++;
      end
      if (drop !== e.dropped) begin
        $error("dropped expected %0d actual %0d", e.dropped, drop);
        errors++;
      end
      if (cnt !== e.sample_count) begin
        $error("sample_count expected %0d actual %0d", e.sample_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;

  median_scoreboard sb;
  bit  calm;          // no idling near the end
  bit  hold_sink;     // long receiver stall
  int  quiet_cycles;

  running_median_two_heaps_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    rst      = 1'b1;
    calm     = 1'b0;
    hold_sink = 1'b0;
  end

  // offers one sample and waits for its transaction
  task automatic send_sample(logic [DATA_W-1:0] v);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(v);
  endtask

  task automatic drain_all();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_sample(int mode);
    case (mode)
      0: return $urandom;
      1: return DATA_W'($urandom_range(0, 40) - 20);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return DATA_W'($urandom_range(0, 2000));
    endcase
  endfunction

  // receiver: random ready bursts, a long hold when asked
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 4);
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog expired with %0d results pending", sb.pending.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] directed[$];
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes, ties, sums that overflow 32 bits, sample between the roots
    directed = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0003,
                 32'hFFFF_FFFD, 32'h0000_0002, 32'h0000_0002, 32'h0000_0002,
                 32'h1234_5678, 32'hFEDC_BA98};
    foreach (directed[i]) send_sample(directed[i]);
    drain_all();

    // fill to capacity with mixed random values, the sink held at the start, then dropped samples
    hold_sink = 1'b1;
    for (int n = 0; n < 1100; n++) send_sample(pick_sample($urandom_range(0, 3)));
    drain_all();
    // sender pause with nothing pending
    for (int n = 0; n < 60; n++) send_sample(pick_sample($urandom_range(0, 3)));
    drain_all();

    // no reset before this stream, so it keeps probing the full state
    for (int n = 0; n < 760; n++) begin
      if (n == 600) calm = 1'b1;
      send_sample(pick_sample($urandom_range(0, 3)));
    end
    drain_all();
    repeat (100) @(posedge clk);

    $display("%0d results checked, %0d of them dropped samples at capacity %0d",
             sb.checked, sb.drops_seen, TOTAL_CAP);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
